[rtl/core/gdsh_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package gdsh_pkg;

	localparam int NODES  = 8;
	localparam int ADJ_W  = NODES * NODES;
	localparam int DEG_W  = 4;
	localparam int CODE_W = 7;
	localparam int IDX_W  = 3;
	localparam int HASH_W = 64;

	localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF29CE484222325;
	localparam logic [HASH_W-1:0] FNV_PRIME = 64'h00000100000001B3;

	// largest real code is 8*9+8, the empty mark sorts above all of them
	localparam logic [CODE_W-1:0] CODE_MAX  = 7'd80;
	localparam logic [CODE_W-1:0] CODE_NONE = 7'h7F;

	typedef logic [CODE_W-1:0] code_t;
	typedef code_t [NODES-1:0] code_vec_t;

	// payload handed from one stage to the next
	typedef struct packed {
		logic [HASH_W-1:0] hash;
		code_vec_t         codes;
		code_t             last;
	} stage_t;

	// one fnv-1a round; the prime is 2^40 + 0x1b3, so the product is a sum of shifts
	function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h, input code_t c);
		logic [HASH_W-1:0] x;
		x = h ^ HASH_W'(c);
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

endpackage

`default_nettype wire

[rtl/core/gdsh_adj_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface gdsh_adj_if import gdsh_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ADJ_W-1:0] adjacency;

	modport source (output valid, output adjacency, input ready);
	modport sink (input valid, input adjacency, output ready);
endinterface

`default_nettype wire

[rtl/core/gdsh_sig_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface gdsh_sig_if import gdsh_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [HASH_W-1:0] signature;

	modport source (output valid, output signature, input ready);
	modport sink (input valid, input signature, output ready);
endinterface

`default_nettype wire

[rtl/core/gdsh_degree.sv]
`timescale 1ns / 1ps
`default_nettype none

module gdsh_degree import gdsh_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             up_valid,
	output logic                  up_ready,
	input  wire logic [ADJ_W-1:0] adjacency,
	output logic                  dn_valid,
	input  wire logic             dn_ready,
	output stage_t                dn_data
);

	logic   valid_q;
	stage_t data_q;
	stage_t next;

	// per-node out/in degree and code out*9+in
	always_comb begin
		logic [NODES-1:0] col [NODES];
		logic [DEG_W-1:0] out_d;
		logic [DEG_W-1:0] in_d;
		next.hash = FNV_BASIS;
		next.last = '0;
		for (int u = 0; u < NODES; u++) begin
			for (int v = 0; v < NODES; v++) begin
				col[u][v] = adjacency[v*NODES + u];
			end
			out_d = DEG_W'($countones(adjacency[u*NODES +: NODES]));
			in_d  = DEG_W'($countones(col[u]));
			next.codes[u] = (CODE_W'(out_d) << 3) + CODE_W'(out_d) + CODE_W'(in_d);
		end
	end

	assign up_ready = !valid_q || dn_ready;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			data_q <= next;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule

`default_nettype wire

[rtl/core/gdsh_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module gdsh_cell import gdsh_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   up_valid,
	output logic        up_ready,
	input  wire stage_t up_data,
	output logic        dn_valid,
	input  wire logic   dn_ready,
	output stage_t      dn_data
);

	logic   valid_q;
	stage_t data_q;
	stage_t next;

	code_t            l1_v [4];
	logic [IDX_W-1:0] l1_i [4];
	code_t            l2_v [2];
	logic [IDX_W-1:0] l2_i [2];
	code_t            min_v;
	logic [IDX_W-1:0] min_i;

	// smallest remaining code, lowest index on a tie
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			if (up_data.codes[2*j+1] < up_data.codes[2*j]) begin
				l1_v[j] = up_data.codes[2*j+1];
				l1_i[j] = IDX_W'(2*j+1);
			end else begin
				l1_v[j] = up_data.codes[2*j];
				l1_i[j] = IDX_W'(2*j);
			end
		end
		for (int j = 0; j < 2; j++) begin
			if (l1_v[2*j+1] < l1_v[2*j]) begin
				l2_v[j] = l1_v[2*j+1];
				l2_i[j] = l1_i[2*j+1];
			end else begin
				l2_v[j] = l1_v[2*j];
				l2_i[j] = l1_i[2*j];
			end
		end
		if (l2_v[1] < l2_v[0]) begin
			min_v = l2_v[1];
			min_i = l2_i[1];
		end else begin
			min_v = l2_v[0];
			min_i = l2_i[0];
		end
	end

	// take the minimum out of the vector and fold it into the hash
	always_comb begin
		for (int j = 0; j < NODES; j++) begin
			next.codes[j] = (IDX_W'(j) == min_i) ? CODE_NONE : up_data.codes[j];
		end
		next.last = min_v;
		next.hash = fnv_step(up_data.hash, min_v);
	end

	assign up_ready = !valid_q || dn_ready;

	// cell valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	// cell payload
	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			data_q <= next;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule

`default_nettype wire

[rtl/core/graph_degree_signature_hash.sv]
// channel  | dir | payload          | bits
// ---------+-----+------------------+-----
// graph    | in  | adjacency        | 64
// result   | out | signature        | 64
//
// one request per cycle is taken while no stall holds the chain; a result passes
// through one degree stage followed by a chain of eight cells, each
// cell pulling the smallest remaining code and folding it into the hash.
// reset clears only the stage valid bits; payload registers are not reset.
// every stage has its own ready, so a stalled result holds the last cell while
// earlier stages keep filling empty slots.
`timescale 1ns / 1ps
`default_nettype none

module graph_degree_signature_hash import gdsh_pkg::*; (
	input wire logic   clk,
	input wire logic   arst_n,
	gdsh_adj_if.sink   graph,
	gdsh_sig_if.source result
);

	logic   stg_valid [NODES+1];
	logic   stg_ready [NODES+1];
	stage_t stg_data  [NODES+1];

	// degree codes
	gdsh_degree u_degree (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (graph.valid),
		.up_ready  (graph.ready),
		.adjacency (graph.adjacency),
		.dn_valid  (stg_valid[0]),
		.dn_ready  (stg_ready[0]),
		.dn_data   (stg_data[0])
	);

	// extract and fold chain
	for (genvar k = 0; k < NODES; k++) begin : g_cell
		gdsh_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (stg_valid[k]),
			.up_ready (stg_ready[k]),
			.up_data  (stg_data[k]),
			.dn_valid (stg_valid[k+1]),
			.dn_ready (stg_ready[k+1]),
			.dn_data  (stg_data[k+1])
		);
	end

	assign result.valid     = stg_valid[NODES];
	assign result.signature = stg_data[NODES].hash;
	assign stg_ready[NODES] = result.ready;

	// checks on the code vectors
	logic codes_in_range;
	logic first_is_min;

	always_comb begin
		codes_in_range = 1'b1;
		first_is_min   = 1'b1;
		for (int j = 0; j < NODES; j++) begin
			if (stg_data[0].codes[j] > CODE_MAX) begin
				codes_in_range = 1'b0;
			end
			if (stg_data[1].codes[j] < stg_data[1].last) begin
				first_is_min = 1'b0;
			end
		end
	end

	a_codes_range: assert property (@(posedge clk) disable iff (!arst_n)
		stg_valid[0] |-> codes_in_range)
		else $error("degree code out of range");

	a_first_min: assert property (@(posedge clk) disable iff (!arst_n)
		stg_valid[1] |-> first_is_min)
		else $error("first cell did not take the smallest code");

	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		stg_valid[NODES] |-> (stg_data[NODES].codes == {NODES{CODE_NONE}}))
		else $error("codes left over at end of chain");

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import gdsh_pkg::*;

	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 5;
	localparam int RANDOM_GRAPHS = 800;
	localparam int HOLD_CYCLES  = 150;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 200000;

	// expected signatures in request order, with a predictor of the hash
	class signature_board;
		logic [HASH_W-1:0] pending[$];
		int errors;
		int checked;

		function new();
			errors  = 0;
			checked = 0;
		endfunction

		// sorted degree codes folded into fnv-1a
		function logic [HASH_W-1:0] signature_of(logic [ADJ_W-1:0] adj);
			code_t deg_code[NODES];
			code_t swap;
			logic [HASH_W-1:0] h;
			int out_deg;
			int in_deg;
			for (int u = 0; u < NODES; u++) begin
				out_deg = 0;
				in_deg  = 0;
				for (int v = 0; v < NODES; v++) begin
					out_deg += adj[u * NODES + v];
					in_deg  += adj[v * NODES + u];
				end
				deg_code[u] = code_t'(out_deg * 9 + in_deg);
			end
			for (int i = 0; i < NODES - 1; i++) begin
				for (int j = 0; j < NODES - 1 - i; j++) begin
					if (deg_code[j] > deg_code[j + 1]) begin
						swap            = deg_code[j];
						deg_code[j]     = deg_code[j + 1];
						deg_code[j + 1] = swap;
					end
				end
			end
			h = FNV_BASIS;
			for (int i = 0; i < NODES; i++) begin
				h = (h ^ HASH_W'(deg_code[i])) * FNV_PRIME;
			end
			return h;
		endfunction

		function void note_graph(logic [ADJ_W-1:0] adj);
			pending.push_back(signature_of(adj));
		endfunction

		task report(string what, logic [HASH_W-1:0] got, logic [HASH_W-1:0] want);
			errors++;
			$display("%0t mismatch: %s got %h want %h", $time, what, got, want);
		endtask

		task check_signature(logic [HASH_W-1:0] got);
			logic [HASH_W-1:0] want;
			checked++;
			if (pending.size() == 0) begin
				report("signature with no request", got, '0);
			end else begin
				want = pending.pop_front();
				if (got !== want)
					report("signature", got, want);
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   cycles;
	int   sent;
	bit   tx_burst;
	bit   rx_burst;
	bit   holding;
	bit   hold_done;
	signature_board board;

	gdsh_adj_if graph_ch();
	gdsh_sig_if result_ch();

	graph_degree_signature_hash uut (
		.clk    (clk),
		.arst_n (arst_n),
		.graph  (graph_ch),
		.result (result_ch)
	);

	// clock
	always #(HALF_PERIOD) clk = ~clk;

	// run watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d signatures outstanding", cycles,
				board.pending.size());
			$display("tb_top: errors");
			$finish;
		end
	end

	// same graph with its nodes renumbered by a random permutation
	function automatic logic [ADJ_W-1:0] relabel(logic [ADJ_W-1:0] adj);
		int perm[NODES];
		int k;
		int swap;
		logic [ADJ_W-1:0] moved;
		for (int i = 0; i < NODES; i++)
			perm[i] = i;
		for (int i = NODES - 1; i > 0; i--) begin
			k       = $urandom_range(0, i);
			swap    = perm[i];
			perm[i] = perm[k];
			perm[k] = swap;
		end
		moved = '0;
		for (int u = 0; u < NODES; u++) begin
			for (int v = 0; v < NODES; v++)
				moved[perm[u] * NODES + perm[v]] = adj[u * NODES + v];
		end
		return moved;
	endfunction

	// offer one request after a random gap, return at the falling edge after acceptance
	task automatic send_graph(input logic [ADJ_W-1:0] adj);
		int gap;
		gap = (tx_burst || holding) ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			graph_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		graph_ch.valid     = 1'b1;
		graph_ch.adjacency = adj;
		@(posedge clk);
		while (!graph_ch.ready)
			@(posedge clk);
		board.note_graph(adj);
		sent++;
		@(negedge clk);
	endtask

	// sparse, dense, uniform or renumbered graph
	task automatic send_random_graph(inout logic [ADJ_W-1:0] prev);
		logic [ADJ_W-1:0] adj;
		int kind;
		kind = $urandom_range(0, 9);
		adj  = {$urandom(), $urandom()};
		if (kind < 2)
			adj = adj & {$urandom(), $urandom()} & {$urandom(), $urandom()};
		else if (kind < 4)
			adj = adj | {$urandom(), $urandom()} | {$urandom(), $urandom()};
		else if (kind < 6)
			adj = relabel(prev);
		prev = adj;
		send_graph(adj);
	endtask

	// result side: random stalls, one long hold-off
	initial begin : result_side
		int stall;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!hold_done && board.checked >= 200) begin
				holding         = 1'b1;
				result_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				holding   = 1'b0;
				hold_done = 1'b1;
			end
			stall = rx_burst ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				result_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ch.ready = 1'b1;
			@(posedge clk);
			while (!result_ch.valid)
				@(posedge clk);
			board.check_signature(result_ch.signature);
			if (board.checked % 50 == 0)
				rx_burst = ($urandom_range(0, 2) == 0);
			@(negedge clk);
		end
	end

	// reset, directed graphs, random graphs, drain
	initial begin : graph_side
		logic [ADJ_W-1:0] directed[$];
		logic [ADJ_W-1:0] prev;
		board              = new();
		clk                = 1'b0;
		arst_n             = 1'b0;
		cycles             = 0;
		sent               = 0;
		tx_burst           = 1'b0;
		rx_burst           = 1'b0;
		holding            = 1'b0;
		hold_done          = 1'b0;
		graph_ch.valid     = 1'b0;
		graph_ch.adjacency = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty, full, lone edges at both ends, self-loops, a full row and column,
		// checkerboards, halves, an out-star and a ring
		directed = '{64'h0, {64{1'b1}}, 64'h1, 64'h8000_0000_0000_0000,
			64'h8040_2010_0804_0201, 64'h0000_0000_0000_00FF, 64'h0101_0101_0101_0101,
			64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'hFFFF_FFFF_0000_0000,
			64'hFF00_0000_0000_0000, 64'h0000_0020_0000_0000, 64'h0180_4020_1008_0402};
		foreach (directed[i])
			send_graph(directed[i]);
		// renumbered copies give equal codes in a new order
		for (int i = 5; i < 13; i++)
			send_graph(relabel(directed[i]));

		prev = directed[12];
		for (int i = 0; i < RANDOM_GRAPHS; i++) begin
			if (i % 40 == 0)
				tx_burst = ($urandom_range(0, 3) == 0);
			send_random_graph(prev);
		end
		graph_ch.valid = 1'b0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d graphs sent (directed extremes, renumbered copies, sparse/dense/uniform)",
			sent);
		$display("%0d signatures checked, long result stall %s, %0d mismatches",
			board.checked, hold_done ? "done" : "missed", board.errors);
		if (board.errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
